// ===== hw/rtl/sirt_pkg.sv =====
package sirt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] data_out;
    logic        [4:0]  entry_count;
    logic               last;
  } res_t;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_insert_remove_table_top.sv =====
// Channel   | Signals                  | Handshake
// ----------+--------------------------+-----------------------------------------
// request   | start_i, req_i, busy_o   | taken at an edge with start_i && !busy_o
// result    | res_valid_o, res_o       | each result shown for a single cycle, cannot be stalled
//
// Insert, remove and no-op take the request in S_IDLE; in S_EXEC the cell row
// compares and shifts in parallel, and the result follows from a register.
// A dump rotates the cell row by one in S_EXEC for each of its N entries,
// emitting the head each time; a dump of an empty table gives one ST_EMPTY result.
// Reset clears the control state and entry count; cell contents are unwritten until inserted.
// busy_o stays high from the request until its last result is produced.
module sorted_insert_remove_table_top
  import sirt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);

  cell_ctrl_t         cell_ctrl;
  logic [CntW-1:0]    count;
  logic signed [31:0] entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] lt;
  logic [MAX_ENTRIES-1:0] match;
  logic               found;

  assign found = |match;

  sirt_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .found_i    (found),
    .head_i     (entry[0]),
    .busy_o     (busy_o),
    .count_o    (count),
    .cell_ctrl_o(cell_ctrl),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic               prev_lt;
    logic signed [31:0] prev_entry;
    logic signed [31:0] next_entry;
    logic               next_valid;

    assign valid[i] = (CntW'(i) < count);

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_lt    = lt[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign next_entry = entry[i];
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_entry = entry[i+1];
      assign next_valid = valid[i+1];
    end

    sirt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .valid_i     (valid[i]),
      .prev_lt_i   (prev_lt),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .next_valid_i(next_valid),
      .head_i      (entry[0]),
      .entry_o     (entry[i]),
      .lt_o        (lt[i]),
      .match_o     (match[i])
    );
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count != $past(count) |->
      (count == CntW'($past(count) + 1'b1)) || (count == CntW'($past(count) - 1'b1)))
    else $error("entry count jumped by more than one");

  a_res_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result without a request in flight");

  // the row is only in order outside a dump rotation
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.op != CELL_ROTATE) |-> $onehot0(match))
    else $error("more than one cell claims the match");

  for (genvar k = 0; k + 1 < MAX_ENTRIES; k++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!busy_o && valid[k+1]) |-> (entry[k] <= entry[k+1]))
      else $error("cell row out of order");
  end

endmodule

// ===== hw/rtl/sirt_cell.sv =====
module sirt_cell
  import sirt_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               valid_i,
  input  logic               prev_lt_i,
  input  logic signed [31:0] prev_entry_i,
  input  logic signed [31:0] next_entry_i,
  input  logic               next_valid_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] entry_o,
  output logic               lt_o,
  output logic               match_o
);

  logic signed [31:0] entry_q, entry_d;

  assign lt_o    = valid_i && (entry_q < ctrl_i.value);
  // first entry that is not smaller; sorted order makes it the first equal one
  assign match_o = valid_i && !lt_o && prev_lt_i && (entry_q == ctrl_i.value);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_HOLD: ;
      CELL_INSERT: begin
        if (!lt_o) begin
          entry_d = prev_lt_i ? ctrl_i.value : prev_entry_i;
        end
      end
      CELL_REMOVE: begin
        if (!lt_o) begin
          entry_d = next_entry_i;
        end
      end
      CELL_ROTATE: begin
        // last valid cell wraps the head around
        if (valid_i) begin
          entry_d = next_valid_i ? next_entry_i : head_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hw/rtl/sirt_ctrl.sv =====
module sirt_ctrl
  import sirt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int CntW        = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  req_t               req_i,
  input  logic               found_i,
  input  logic signed [31:0] head_i,
  output logic               busy_o,
  output logic [CntW-1:0]    count_o,
  output cell_ctrl_t         cell_ctrl_o,
  output logic               res_valid_o,
  output res_t               res_o
);

  localparam int PadW = CntW + 5;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;
  logic [PadW-1:0] count_wide;
  logic            dump_last;
  logic            full;

  assign full      = (count_q == CntW'(MAX_ENTRIES));
  assign dump_last = (idx_q == CntW'(count_q - 1'b1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q.cmd == CMD_DUMP && count_q != '0 && !dump_last) begin
          state_d = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cell_ctrl_o.op    = CELL_HOLD;
    cell_ctrl_o.value = req_q.value;
    req_d             = req_q;
    count_d           = count_q;
    idx_d             = idx_q;
    res_valid_d       = 1'b0;
    res_d             = res_q;
    count_wide        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          idx_d = '0;
        end
      end
      S_EXEC: begin
        res_valid_d   = 1'b1;
        res_d.status  = ST_OK;
        res_d.data_out = req_q.value;
        res_d.last    = 1'b1;
        unique case (req_q.cmd)
          CMD_INSERT: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              cell_ctrl_o.op = CELL_INSERT;
              count_d        = count_q + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (found_i) begin
              cell_ctrl_o.op = CELL_REMOVE;
              count_d        = count_q - 1'b1;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          CMD_DUMP: begin
            if (count_q == '0) begin
              res_d.status   = ST_EMPTY;
              res_d.data_out = '0;
            end else begin
              // emit the head and rotate the row by one
              cell_ctrl_o.op = CELL_ROTATE;
              res_d.data_out = head_i;
              res_d.last     = dump_last;
              idx_d          = idx_q + 1'b1;
            end
          end
          CMD_NOP: ;
        endcase
        count_wide        = PadW'(count_d);
        res_d.entry_count = count_wide[4:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign count_o     = count_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
